### hdl/fpr_pkg.sv
// Package for the Fermat primality round block.
// Holds stream widths and verdict codes; it depends on nothing else.
package fpr_pkg;

    // Widths of the item fields as they appear on the stream ports.
    localparam int CAND_W    = 32;
    localparam int RAND_W    = 31;
    localparam int VERDICT_W = 2;
    localparam int BASE_W    = 32;

    // Index width for walking the random word from its top bit down.
    localparam int RIDX_W = $clog2(RAND_W);

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((CAND_W + RAND_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VERDICT_W + BASE_W + 7) / 8) * 8;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_PRIME   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FACTOR  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FERMAT  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd3;

endpackage

### hdl/fpr_modadd.sv
// Shared arithmetic unit of the Fermat round: a conditional modular adder.
// Stand-alone; the top level drives its operands from a small sequencer.
module fpr_modadd #(
    parameter int W = 32
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic         carry_in,
    input  logic [W-1:0] modulus,
    output logic [W-1:0] result,
    output logic         reduced
);

    logic [W:0] sum;
    logic [W:0] diff;

    // One wide add, one compare and one subtract of the modulus.
    assign sum     = {1'b0, op_a} + {1'b0, op_b} + {{W{1'b0}}, carry_in};
    assign reduced = (sum >= {1'b0, modulus});
    assign diff    = sum - {1'b0, modulus};
    assign result  = reduced ? diff[W-1:0] : sum[W-1:0];

endmodule

### hdl/fermat_primality_round.sv
// Top level of the Fermat primality round: sequencer, operand registers and streams.
// Depends on fpr_pkg and on the shared unit fpr_modadd.
//
// One item runs one Fermat round on the low NUM_WIDTH bits of the candidate. The
// block takes one item at a time and holds s_tready low until the round's result
// is loaded into the output register; a result that waits there does not stop the
// next item from being taken. All modular steps go through a single modular
// adder that does one add-and-reduce per cycle. A round reduces the random word
// bit by bit from the top, forms the base and runs a binary gcd, then a
// square-and-multiply over W = NUM_WIDTH exponent bits in which each modular
// product has a doubling step for every multiplier bit, one more step for every
// set bit and a closing step. A shared factor ends the round before the
// exponentiation, and candidates 0, 1 and 2 go straight to the output.
module fermat_primality_round #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata fields, low bit up: candidate [31:0], random_word [62:32], zero pad.
    input  logic [fpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata fields, low bit up: verdict [1:0], base_used [33:2], zero pad.
    output logic [fpr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import fpr_pkg::*;

    localparam int W     = NUM_WIDTH;
    localparam int IDX_W = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_BASE,
        S_GCD,
        S_MUL_DBL,
        S_MUL_ADD,
        S_MUL_END,
        S_OUT
    } state_t;

    state_t              state_reg,   state_next;
    logic [W-1:0]        n_reg,       n_next;
    logic [W-1:0]        d_reg,       d_next;
    logic [W-1:0]        e_reg,       e_next;
    logic [RAND_W-1:0]   w_reg,       w_next;
    logic [W-1:0]        base_reg,    base_next;
    logic [W-1:0]        acc_reg,     acc_next;
    logic [W-1:0]        p_reg,       p_next;
    logic [W-1:0]        u_reg,       u_next;
    logic [W-1:0]        v_reg,       v_next;
    logic [RIDX_W-1:0]   ridx_reg,    ridx_next;
    logic [IDX_W-1:0]    j_reg,       j_next;
    logic [IDX_W-1:0]    k_reg,       k_next;
    logic                sq_reg,      sq_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [W-1:0] unit_a;
    logic [W-1:0] unit_b;
    logic         unit_cin;
    logic [W-1:0] unit_m;
    logic [W-1:0] unit_res;
    logic         unit_ge;

    logic [W-1:0] cand_in;
    logic [W-1:0] base_sum;
    logic [W-1:0] mul_x;
    logic         out_free;

    assign cand_in  = s_tdata[W-1:0];
    assign base_sum = p_reg + W'(2);
    assign mul_x    = sq_reg ? acc_reg : base_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Operand selection for the shared modular adder.
    always_comb begin
        unit_a   = p_reg;
        unit_b   = p_reg;
        unit_cin = 1'b0;
        unit_m   = n_reg;
        case (state_reg)
            S_REM: begin
                unit_cin = w_reg[ridx_reg];
                unit_m   = d_reg;
            end
            S_GCD: begin
                unit_a = u_reg;
                unit_b = '0;
                unit_m = v_reg;
            end
            S_MUL_ADD: begin
                unit_b = acc_reg;
            end
            default: begin
            end
        endcase
    end

    fpr_modadd #(
        .W (W)
    ) u_modadd (
        .op_a     (unit_a),
        .op_b     (unit_b),
        .carry_in (unit_cin),
        .modulus  (unit_m),
        .result   (unit_res),
        .reduced  (unit_ge)
    );

    // Sequencer: next values of all registers.
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        w_next        = w_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        p_next        = p_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        ridx_next     = ridx_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        sq_next       = sq_reg;
        verdict_next  = verdict_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // A waiting result leaves once it is taken.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            // Take an item; small candidates are settled at once.
            S_IDLE: begin
                if (s_tvalid) begin
                    n_next    = cand_in;
                    d_next    = cand_in - W'(2);
                    e_next    = cand_in - W'(1);
                    w_next    = s_tdata[CAND_W +: RAND_W];
                    p_next    = '0;
                    ridx_next = RIDX_W'(RAND_W - 1);
                    if (cand_in <= W'(1)) begin
                        verdict_next = VERDICT_INVALID;
                        base_next    = '0;
                        state_next   = S_OUT;
                    end else if (cand_in == W'(2)) begin
                        verdict_next = VERDICT_PRIME;
                        base_next    = W'(2);
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_REM;
                    end
                end
            end

            // Random word mod (candidate - 2), one bit per cycle from the top.
            S_REM: begin
                p_next = unit_res;
                if (ridx_reg == '0) begin
                    state_next = S_BASE;
                end else begin
                    ridx_next = ridx_reg - RIDX_W'(1);
                end
            end

            // Form the base; both even means a shared factor of two.
            S_BASE: begin
                base_next = base_sum;
                u_next    = base_sum;
                v_next    = n_reg;
                if (!base_sum[0] && !n_reg[0]) begin
                    verdict_next = VERDICT_FACTOR;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_GCD;
                end
            end

            // Binary gcd: one odd value is always kept, so factors of two drop out.
            S_GCD: begin
                if (u_reg == v_reg) begin
                    if (u_reg == W'(1)) begin
                        acc_next   = W'(1);
                        k_next     = IDX_W'(W - 1);
                        sq_next    = 1'b1;
                        p_next     = '0;
                        j_next     = IDX_W'(W - 1);
                        state_next = S_MUL_DBL;
                    end else begin
                        verdict_next = VERDICT_FACTOR;
                        state_next   = S_OUT;
                    end
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (unit_ge) begin
                    u_next = unit_res;
                end else begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end

            // Interleaved modular product: double the partial result.
            S_MUL_DBL: begin
                p_next = unit_res;
                if (mul_x[j_reg]) begin
                    state_next = S_MUL_ADD;
                end else if (j_reg == '0) begin
                    state_next = S_MUL_END;
                end else begin
                    j_next = j_reg - IDX_W'(1);
                end
            end

            // Add the multiplicand for a set multiplier bit.
            S_MUL_ADD: begin
                p_next = unit_res;
                if (j_reg == '0) begin
                    state_next = S_MUL_END;
                end else begin
                    j_next     = j_reg - IDX_W'(1);
                    state_next = S_MUL_DBL;
                end
            end

            // Product done: pick the next square or multiply, or finish.
            S_MUL_END: begin
                acc_next = p_reg;
                p_next   = '0;
                j_next   = IDX_W'(W - 1);
                if (sq_reg && e_reg[k_reg]) begin
                    sq_next    = 1'b0;
                    state_next = S_MUL_DBL;
                end else if (k_reg == '0) begin
                    verdict_next = (p_reg == W'(1)) ? VERDICT_PRIME : VERDICT_FERMAT;
                    state_next   = S_OUT;
                end else begin
                    k_next     = k_reg - IDX_W'(1);
                    sq_next    = 1'b1;
                    state_next = S_MUL_DBL;
                end
            end

            // Load the output register once it is free.
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({BASE_W'(base_reg), verdict_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            n_reg        <= n_next;
            d_reg        <= d_next;
            e_reg        <= e_next;
            w_reg        <= w_next;
            base_reg     <= base_next;
            acc_reg      <= acc_next;
            p_reg        <= p_next;
            u_reg        <= u_next;
            v_reg        <= v_next;
            ridx_reg     <= ridx_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            sq_reg       <= sq_next;
            verdict_reg  <= verdict_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

### hdl/fpr_checker.sv
// Port-level checks for the Fermat primality round, bound to the top level.
// Depends on fpr_pkg for widths and verdict codes.
module fpr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [fpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fpr_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import fpr_pkg::*;

    logic [VERDICT_W-1:0] verdict;
    logic [BASE_W-1:0]    base_used;

    assign verdict   = m_tdata[VERDICT_W-1:0];
    assign base_used = m_tdata[VERDICT_W +: BASE_W];

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The block works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // An invalid candidate reports a zero base.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (verdict == VERDICT_INVALID) |-> (base_used == '0))
        else $error("invalid verdict with nonzero base");

    // Every tested base is at least two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (verdict != VERDICT_INVALID) |-> (base_used >= BASE_W'(2)))
        else $error("tested base below two");

endmodule

bind fermat_primality_round fpr_checker u_fpr_checker (.*);

### sim/fpr_round_checker.sv
`timescale 1ns / 1ps
// Checker for the Fermat primality round: watches both streams, predicts each round
// and compares the verdict and base. Depends on fpr_pkg.
module fpr_round_checker #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fpr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fpr_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              n_errors,
    output int                              n_pending,
    output int                              n_results,
    output int                              n_prime,
    output int                              n_factor,
    output int                              n_fermat,
    output int                              n_invalid
);
    import fpr_pkg::*;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [BASE_W-1:0]    base_used;
    } round_result_t;

    round_result_t pending_rounds [$];

    int error_count   = 0;
    int result_count  = 0;
    int prime_count   = 0;
    int factor_count  = 0;
    int fermat_count  = 0;
    int invalid_count = 0;

    assign n_errors  = error_count;
    assign n_pending = pending_rounds.size();
    assign n_results = result_count;
    assign n_prime   = prime_count;
    assign n_factor  = factor_count;
    assign n_fermat  = fermat_count;
    assign n_invalid = invalid_count;

    // One Fermat round on the low NUM_WIDTH bits of the candidate. Operands stay
    // below 2^32, so every modular product fits in 64 bits.
    function automatic round_result_t fermat_round(logic [CAND_W-1:0] cand,
                                                   logic [RAND_W-1:0] word);
        bit [63:0]     n;
        bit [63:0]     base;
        bit [63:0]     ga;
        bit [63:0]     gb;
        bit [63:0]     rem;
        bit [63:0]     acc;
        bit [63:0]     sq;
        bit [63:0]     ex;
        round_result_t res;
        n = {32'd0, cand} & ((64'd1 << NUM_WIDTH) - 64'd1);
        if (n < 2) begin
            res.verdict   = VERDICT_INVALID;
            res.base_used = '0;
            return res;
        end
        if (n == 2) begin
            res.verdict   = VERDICT_PRIME;
            res.base_used = BASE_W'(2);
            return res;
        end
        base = ({33'd0, word} % (n - 2)) + 2;
        res.base_used = base[BASE_W-1:0];
        // Euclid on the base and the candidate.
        ga = base;
        gb = n;
        while (gb != 0) begin
            rem = ga % gb;
            ga  = gb;
            gb  = rem;
        end
        if (ga != 1) begin
            res.verdict = VERDICT_FACTOR;
            return res;
        end
        // Square-and-multiply for base^(n-1) mod n.
        acc = 1;
        sq  = base % n;
        ex  = n - 1;
        while (ex != 0) begin
            if (ex[0])
                acc = (acc * sq) % n;
            sq = (sq * sq) % n;
            ex = ex >> 1;
        end
        res.verdict = (acc != 1) ? VERDICT_FERMAT : VERDICT_PRIME;
        return res;
    endfunction

    // Results are checked before new items are queued: a result never belongs to
    // an item taken at the same edge.
    always @(posedge aclk) begin
        round_result_t want;
        round_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.verdict   = m_tdata[VERDICT_W-1:0];
                got.base_used = m_tdata[VERDICT_W +: BASE_W];
                result_count++;
                if (pending_rounds.size() == 0) begin
                    $error("Result item with no round pending: verdict %0d base %0d",
                           got.verdict, got.base_used);
                    error_count++;
                end else begin
                    want = pending_rounds.pop_front();
                    if (got.verdict !== want.verdict) begin
                        $error("verdict mismatch: expected %0d, actual %0d",
                               want.verdict, got.verdict);
                        error_count++;
                    end
                    if (got.base_used !== want.base_used) begin
                        $error("base_used mismatch: expected %0d, actual %0d",
                               want.base_used, got.base_used);
                        error_count++;
                    end
                    case (want.verdict)
                        VERDICT_PRIME:  prime_count++;
                        VERDICT_FACTOR: factor_count++;
                        VERDICT_FERMAT: fermat_count++;
                        default:        invalid_count++;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                pending_rounds.push_back(fermat_round(s_tdata[CAND_W-1:0],
                                                      s_tdata[CAND_W +: RAND_W]));
        end
    end

endmodule

### sim/fermat_primality_round_tb.sv
`timescale 1ns / 1ps
// Testbench top for the Fermat primality round: clock, reset, stimulus and verdict.
// Depends on fpr_pkg, the block fermat_primality_round and fpr_round_checker.
module fermat_primality_round_tb;
    import fpr_pkg::*;

    localparam int NUM_WIDTH     = 32;
    localparam int RANDOM_ITEMS  = 265;
    localparam int HOLD_CYCLES   = 12000;
    localparam int IDLE_LIMIT    = 40000;
    localparam int TAIL_CYCLES   = 64;

    logic                   aclk;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;

    int n_errors;
    int n_pending;
    int n_results;
    int n_prime;
    int n_factor;
    int n_fermat;
    int n_invalid;

    int items_sent  = 0;
    int idle_cycles = 0;
    bit run_active  = 0;

    fermat_primality_round #(
        .NUM_WIDTH(NUM_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    fpr_round_checker #(
        .NUM_WIDTH(NUM_WIDTH)
    ) i_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .n_errors (n_errors),
        .n_pending(n_pending),
        .n_results(n_results),
        .n_prime  (n_prime),
        .n_factor (n_factor),
        .n_fermat (n_fermat),
        .n_invalid(n_invalid)
    );

    // Clock with a 4 ns period.
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The watchdog ends the run when neither stream moves for too long.
    always @(posedge aclk) begin
        if (run_active) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off that fills the block, and a
    // stretch where it always accepts.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && n_results >= 20) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (n_results >= 60 && n_results < 120)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 13);
        end
    end

    // Offers one item, with a random gap before it outside the steady stretch.
    task automatic offer_round(input logic [CAND_W-1:0] cand, input logic [RAND_W-1:0] word);
        int gap;
        gap = 0;
        if (!(items_sent >= 120 && items_sent < 180) && $urandom_range(0, 99) < 13)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - CAND_W - RAND_W){1'b0}}, word, cand};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Smallest prime not below start, by trial division; start stays small.
    function automatic logic [CAND_W-1:0] prime_from(logic [CAND_W-1:0] start);
        logic [CAND_W-1:0] n;
        logic [CAND_W-1:0] d;
        bit                found;
        n     = (start < 2) ? CAND_W'(2) : start;
        found = 1'b0;
        while (!found) begin
            found = 1'b1;
            for (d = 2; d * d <= n; d++) begin
                if (n % d == 0) begin
                    found = 1'b0;
                    break;
                end
            end
            if (!found)
                n++;
        end
        return n;
    endfunction

    // Primes, most near the top of the 31- and 32-bit ranges.
    function automatic logic [CAND_W-1:0] large_prime(int k);
        case (k)
            0:       return 32'd4294967291;
            1:       return 32'd4294967279;
            2:       return 32'd4294967231;
            3:       return 32'd4294967197;
            4:       return 32'd4294967189;
            5:       return 32'd2147483647;
            6:       return 32'd2147483629;
            7:       return 32'd2147483587;
            8:       return 32'd1000000007;
            9:       return 32'd1000000009;
            10:      return 32'd998244353;
            default: return 32'd65521;
        endcase
    endfunction

    // Carmichael numbers and base-2 pseudoprimes: composites that often pass.
    function automatic logic [CAND_W-1:0] liar_composite(int k);
        case (k)
            0:       return 32'd561;
            1:       return 32'd1105;
            2:       return 32'd1729;
            3:       return 32'd2465;
            4:       return 32'd2821;
            5:       return 32'd6601;
            6:       return 32'd8911;
            7:       return 32'd41041;
            8:       return 32'd825265;
            9:       return 32'd3215031751;
            10:      return 32'd341;
            default: return 32'd2047;
        endcase
    endfunction

    function automatic logic [CAND_W-1:0] pick_candidate();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return CAND_W'($urandom_range(0, 3));
        else if (sel < 40)
            return prime_from($urandom & ((32'd1 << $urandom_range(2, 22)) - 1));
        else if (sel < 55)
            return large_prime($urandom_range(0, 11));
        else if (sel < 65)
            return liar_composite($urandom_range(0, 11));
        else if (sel < 80)
            return $urandom;
        else
            return CAND_W'($urandom & (33'h1_0000_0000 - 1 >> $urandom_range(0, 30)));
    endfunction

    // The random word is mostly uniform, sometimes narrow, and sometimes placed
    // so that the base lands on 2, 3 or candidate-1 when the candidate is below 2^31.
    function automatic logic [RAND_W-1:0] pick_word(logic [CAND_W-1:0] cand);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return RAND_W'($urandom);
        else if (sel < 90)
            return RAND_W'($urandom & ((32'd1 << $urandom_range(1, 31)) - 1));
        else if (cand >= 3)
            return RAND_W'(cand - 32'd3 + $urandom_range(0, 2));
        else
            return RAND_W'($urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0);
    endfunction

    // Reset, directed rounds, random rounds, drain and verdict.
    initial begin : stimulus
        logic [CAND_W-1:0] cand;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(negedge aclk);
        aresetn    <= 1'b1;
        run_active <= 1'b1;
        @(negedge aclk);

        // Invalid candidates, the immediate two, candidate 3 whose base is fixed, and 5.
        offer_round(32'd0, 31'h0);
        offer_round(32'd1, 31'h7FFFFFFF);
        offer_round(32'd2, 31'h7FFFFFFF);
        offer_round(32'd2, 31'h0);
        offer_round(32'd3, 31'h0);
        offer_round(32'd3, 31'h7FFFFFFF);
        offer_round(32'd5, 31'h7FFFFFFF);
        // Small composites: Fermat failure, liar bases and a shared factor; then the prime 65537.
        offer_round(32'd4, 31'd1);
        offer_round(32'd9, 31'd0);
        offer_round(32'd15, 31'd2);
        offer_round(32'd21, 31'd1);
        offer_round(32'd341, 31'd0);
        offer_round(32'd561, 31'd0);
        offer_round(32'd65537, 31'd12345);
        // Extremes of both fields and alternating bit patterns.
        offer_round(32'hFFFFFFFF, 31'h7FFFFFFF);
        offer_round(32'hFFFFFFFF, 31'h0);
        offer_round(32'hFFFFFFFB, 31'h0);
        offer_round(32'hFFFFFFFB, 31'h7FFFFFFF);
        offer_round(32'h7FFFFFFF, 31'h7FFFFFFC);
        offer_round(32'h7FFFFFFF, 31'h7FFFFFFD);
        offer_round(32'h80000000, 31'h55555555);
        offer_round(32'hAAAAAAAA, 31'h2AAAAAAA);
        offer_round(32'h55555555, 31'h55555555);

        repeat (RANDOM_ITEMS) begin
            cand = pick_candidate();
            offer_round(cand, pick_word(cand));
        end
        s_tvalid <= 1'b0;

        while (n_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d rounds: %0d probable prime, %0d shared factor, %0d Fermat fail,",
                 items_sent, n_prime, n_factor, n_fermat);
        $display("%0d invalid. Candidates spanned 0 to 2^32-1 with primes, liars and",
                 n_invalid);
        $display("random values, with one long output hold-off.");
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
